/* src/tdf_pkg.sv */
// Shared constants, types and tile orientation functions for the tile dedup block.
`timescale 1ns / 1ps
package tdf_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = 9;
  localparam int IDX_W       = 8;
  localparam int PLANE_W     = 64;
  localparam int TILE_W      = 2 * PLANE_W;
  localparam int NUM_ORIENT  = 4;

  // Orientation order: none, horizontal, vertical, both.
  localparam logic [NUM_ORIENT-1:0] ORIENT_HF = 4'b1010;
  localparam logic [NUM_ORIENT-1:0] ORIENT_VF = 4'b1100;

  typedef logic [TILE_W-1:0] tile_t;

  typedef struct packed {
    logic hit;
    logic hf;
    logic vf;
  } match_t;

  // Reverse the bits of every row byte.
  function automatic logic [PLANE_W-1:0] mirror_rows(input logic [PLANE_W-1:0] v);
    logic [PLANE_W-1:0] r;
    r = '0;
    for (int row = 0; row < 8; row++) begin
      for (int b = 0; b < 8; b++) begin
        r[8*row + b] = v[8*row + 7 - b];
      end
    end
    return r;
  endfunction

  // Reverse the row order.
  function automatic logic [PLANE_W-1:0] swap_rows(input logic [PLANE_W-1:0] v);
    logic [PLANE_W-1:0] r;
    r = '0;
    for (int row = 0; row < 8; row++) begin
      r[8*row +: 8] = v[8*(7 - row) +: 8];
    end
    return r;
  endfunction

  function automatic logic [PLANE_W-1:0] orient_plane(input logic [PLANE_W-1:0] v,
                                                      input logic fh, input logic fv);
    logic [PLANE_W-1:0] r;
    r = v;
    if (fh) begin
      r = mirror_rows(r);
    end
    if (fv) begin
      r = swap_rows(r);
    end
    return r;
  endfunction

  // Tile word is {high plane, low plane}.
  function automatic tile_t orient_tile(input logic [PLANE_W-1:0] lo,
                                        input logic [PLANE_W-1:0] hi,
                                        input logic fh, input logic fv);
    return {orient_plane(hi, fh, fv), orient_plane(lo, fh, fv)};
  endfunction

endpackage

/* src/tile_dedup_with_flip_match.sv */
// Top level: tile deduplication table with flip matching, scanned from one RAM.
`timescale 1ns / 1ps
// A miss reads every stored entry, one RAM read per entry, before done rises; a hit at
//   entry i ends the scan there. busy holds for the whole scan, and start is taken in
//   the done cycle, so a new request is only taken once the last one is through.
// Reset clears the entry count and the control state; RAM contents are kept but never
//   read until rewritten. Results are shown for one cycle and cannot be held off.
module tile_dedup_with_flip_match
  import tdf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               clear_table,
  input  logic [PLANE_W-1:0] plane_low,
  input  logic [PLANE_W-1:0] plane_high,
  output logic               done,
  output logic [IDX_W-1:0]   tile_index,
  output logic               horizontal_flip,
  output logic               vertical_flip,
  output logic               newly_added,
  output logic               status,
  output logic [CNT_W-1:0]   entry_count
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  logic                   state;
  logic [CNT_W-1:0]       count;       // entries held
  logic [CNT_W-1:0]       scan_addr;   // next entry to read
  logic                   rd_pend;     // RAM data for rd_addr arrives this cycle
  logic [ADDR_W-1:0]      rd_addr;
  tile_t [NUM_ORIENT-1:0] cand;        // request in all four orientations

  tile_t  rd_data;
  match_t m;

  logic hit;
  logic issue;
  logic finish_miss;
  logic full;
  logic ram_we;

  tdf_ram #(
    .WIDTH(TILE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (cand[0]),
    .re    (issue),
    .raddr (scan_addr[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  tdf_match u_match (
    .stored (rd_data),
    .cand   (cand),
    .result (m)
  );

  // Scan control: a read is issued each cycle while entries remain and no hit has
  // been found, and the data of the previous read is compared in the same cycle.
  always_comb begin
    hit         = (state == ST_SCAN) && rd_pend && m.hit;
    issue       = (state == ST_SCAN) && !hit && (scan_addr < count);
    finish_miss = (state == ST_SCAN) && !hit && !issue && !rd_pend;
    full        = (count >= FULL_COUNT);
    ram_we      = finish_miss && !full;
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      scan_addr <= '0;
      rd_pend   <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            // Drop the table first when asked; old entries are simply never read.
            if (clear_table) begin
              count <= '0;
            end
            scan_addr <= '0;
            rd_pend   <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          priority if (hit) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else if (issue) begin
            rd_pend   <= 1'b1;
            scan_addr <= scan_addr + 1'b1;
          end else if (rd_pend) begin
            // Last entry compared without a hit; decide the miss next cycle.
            rd_pend <= 1'b0;
          end else begin
            if (!full) begin
              count <= count + 1'b1;
            end
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: request orientations, read address and the result.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      for (int k = 0; k < NUM_ORIENT; k++) begin
        cand[k] <= orient_tile(plane_low, plane_high, ORIENT_HF[k], ORIENT_VF[k]);
      end
    end
    if (issue) begin
      rd_addr <= scan_addr[ADDR_W-1:0];
    end
    if (hit) begin
      tile_index      <= IDX_W'(rd_addr);
      horizontal_flip <= m.hf;
      vertical_flip   <= m.vf;
      newly_added     <= 1'b0;
      status          <= 1'b0;
      entry_count     <= count;
    end else if (finish_miss) begin
      if (full) begin
        tile_index  <= '0;
        newly_added <= 1'b0;
        status      <= 1'b1;
        entry_count <= count;
      end else begin
        tile_index  <= IDX_W'(count[ADDR_W-1:0]);
        newly_added <= 1'b1;
        status      <= 1'b0;
        entry_count <= count + 1'b1;
      end
      horizontal_flip <= 1'b0;
      vertical_flip   <= 1'b0;
    end
  end

endmodule

/* src/tdf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module tdf_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/tdf_match.sv */
// Compares one stored tile with the four orientations of the requested tile.
`timescale 1ns / 1ps
module tdf_match
  import tdf_pkg::*;
(
  input  tile_t                  stored,
  input  tile_t [NUM_ORIENT-1:0] cand,
  output match_t                 result
);

  // Flips are involutions and commute, so comparing the stored entry with the
  // flipped request equals comparing the flipped entry with the request.
  always_comb begin
    result = '0;
    for (int k = NUM_ORIENT - 1; k >= 0; k--) begin
      if (stored == cand[k]) begin
        result.hit = 1'b1;
        result.hf  = ORIENT_HF[k];
        result.vf  = ORIENT_VF[k];
      end
    end
  end

endmodule

/* verif/tb.sv */
// Testbench for the tile dedup block: directed and random tile requests checked per field.
`timescale 1ns / 1ps
module tb
  import tdf_pkg::*;
();

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;
  localparam int   RANDOM_TILES = 600;
  localparam int   SETTLE_CYCLES = TABLE_DEPTH + 8;
  localparam int   DRAIN_LIMIT = 4 * (TABLE_DEPTH + 8);
  localparam int   TIMEOUT_NS = 8_000_000;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             hflip;
    logic             vflip;
    logic             added;
    logic             stat;
    logic [CNT_W-1:0] count;
  } tile_match_t;

  // Mirror of the dedup table: predicts the match for each accepted tile and
  // holds the predictions until the block reports them.
  class dedup_book;
    logic [PLANE_W-1:0] lo_store [TABLE_DEPTH];
    logic [PLANE_W-1:0] hi_store [TABLE_DEPTH];
    int unsigned        held;
    tile_match_t        expected_matches [$];
    int                 failures;

    function new();
      held = 0;
      failures = 0;
    endfunction

    // Row r takes row 7 - r on a vertical flip; bit b takes bit 7 - b on a horizontal one.
    static function logic [PLANE_W-1:0] turn_plane(logic [PLANE_W-1:0] v, logic hf, logic vf);
      logic [PLANE_W-1:0] r;
      for (int row = 0; row < 8; row++) begin
        for (int col = 0; col < 8; col++) begin
          r[8*row + col] = v[8*(vf ? 7 - row : row) + (hf ? 7 - col : col)];
        end
      end
      return r;
    endfunction

    function void note_tile(logic clr, logic [PLANE_W-1:0] lo, logic [PLANE_W-1:0] hi);
      tile_match_t want;
      bit          found;
      want = '0;
      found = 0;
      if (clr) begin
        held = 0;
      end
      // Scan entries in order; within an entry the orientation order decides.
      for (int e = 0; e < held && !found; e++) begin
        for (int k = 0; k < NUM_ORIENT && !found; k++) begin
          if (turn_plane(lo_store[e], ORIENT_HF[k], ORIENT_VF[k]) == lo &&
              turn_plane(hi_store[e], ORIENT_HF[k], ORIENT_VF[k]) == hi) begin
            found = 1;
            want.index = IDX_W'(e);
            want.hflip = ORIENT_HF[k];
            want.vflip = ORIENT_VF[k];
          end
        end
      end
      if (!found) begin
        if (held >= TABLE_DEPTH) begin
          want.stat = STATUS_FULL;
        end else begin
          lo_store[held] = lo;
          hi_store[held] = hi;
          want.index = IDX_W'(held);
          want.added = 1'b1;
          want.stat = STATUS_OK;
          held++;
        end
      end
      want.count = CNT_W'(held);
      expected_matches.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_match(tile_match_t got);
      tile_match_t want;
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected result, expected none, got index %0d count %0d",
                 $time, got.index, got.count);
        failures++;
        return;
      end
      want = expected_matches.pop_front();
      compare_field("tile_index", 32'(want.index), 32'(got.index));
      compare_field("horizontal_flip", 32'(want.hflip), 32'(got.hflip));
      compare_field("vertical_flip", 32'(want.vflip), 32'(got.vflip));
      compare_field("newly_added", 32'(want.added), 32'(got.added));
      compare_field("status", 32'(want.stat), 32'(got.stat));
      compare_field("entry_count", 32'(want.count), 32'(got.count));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic               clear_table;
  logic [PLANE_W-1:0] plane_low;
  logic [PLANE_W-1:0] plane_high;
  logic               done;
  logic [IDX_W-1:0]   tile_index;
  logic               horizontal_flip;
  logic               vertical_flip;
  logic               newly_added;
  logic               status;
  logic [CNT_W-1:0]   entry_count;

  dedup_book book = new();
  int        requests_sent = 0;
  bit        allow_idle = 1;

  always #2 clk = ~clk;

  tile_dedup_with_flip_match dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .clear_table     (clear_table),
    .plane_low       (plane_low),
    .plane_high      (plane_high),
    .done            (done),
    .tile_index      (tile_index),
    .horizontal_flip (horizontal_flip),
    .vertical_flip   (vertical_flip),
    .newly_added     (newly_added),
    .status          (status),
    .entry_count     (entry_count)
  );

  // Results cannot be held off: check every strobe at the edge that ends it.
  always @(posedge clk) begin
    if (rst === 1'b0 && done === 1'b1) begin
      book.check_match({tile_index, horizontal_flip, vertical_flip, newly_added, status,
                        entry_count});
    end
  end

  function automatic logic [PLANE_W-1:0] random_plane();
    return {$urandom, $urandom};
  endfunction

  // Hold the request until the block takes it; start stays high for a follow-on request.
  task automatic issue_tile(input logic clr, input logic [PLANE_W-1:0] lo,
                            input logic [PLANE_W-1:0] hi);
    start <= 1'b1;
    clear_table <= clr;
    plane_low <= lo;
    plane_high <= hi;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    book.note_tile(clr, lo, hi);
    requests_sent++;
  endtask

  // Drop start for a while and put junk on the data inputs; the block must ignore it.
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    clear_table <= 1'($urandom_range(1));
    plane_low <= random_plane();
    plane_high <= random_plane();
    repeat (cycles) @(posedge clk);
  endtask

  // Idle now and then; long gaps land anywhere in a scan, short ones near its end.
  task automatic maybe_idle();
    if (allow_idle && $urandom_range(99) < 36) begin
      if ($urandom_range(1)) begin
        hold_off($urandom_range(1, 3));
      end else begin
        hold_off($urandom_range(1, book.held + 4));
      end
    end
  endtask

  task automatic wait_for_drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (book.expected_matches.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // One run of requests on a table that starts cleared or not. fresh_pct sets the fresh
  // share, odd shapes take up to a tenth, the rest reuse a stored tile, randomly flipped.
  task automatic run_episode(input int length, input int fresh_pct, input bit open_clear);
    logic               clr;
    logic [PLANE_W-1:0] lo;
    logic [PLANE_W-1:0] hi;
    int                 pick;
    int                 e;
    int                 k;
    for (int n = 0; n < length; n++) begin
      pick = $urandom_range(99);
      clr = (open_clear && n == 0) || ($urandom_range(99) < 3);
      lo = random_plane();
      hi = random_plane();
      if (pick < 90 - fresh_pct && book.held > 0) begin
        e = $urandom_range(book.held - 1);
        k = $urandom_range(NUM_ORIENT - 1);
        lo = dedup_book::turn_plane(book.lo_store[e], ORIENT_HF[k], ORIENT_VF[k]);
        hi = dedup_book::turn_plane(book.hi_store[e], ORIENT_HF[k], ORIENT_VF[k]);
      end else if (pick < 100 - fresh_pct) begin
        case ($urandom_range(4))
          0: begin
            // left-right symmetric rows
            lo = (lo & 64'hF0F0F0F0F0F0F0F0) |
                 (dedup_book::turn_plane(lo, 1'b1, 1'b0) & 64'h0F0F0F0F0F0F0F0F);
            hi = (hi & 64'hF0F0F0F0F0F0F0F0) |
                 (dedup_book::turn_plane(hi, 1'b1, 1'b0) & 64'h0F0F0F0F0F0F0F0F);
          end
          1: begin
            // top-bottom symmetric rows
            lo = (lo & 64'hFFFFFFFF00000000) |
                 (dedup_book::turn_plane(lo, 1'b0, 1'b1) & 64'h00000000FFFFFFFF);
            hi = (hi & 64'hFFFFFFFF00000000) |
                 (dedup_book::turn_plane(hi, 1'b0, 1'b1) & 64'h00000000FFFFFFFF);
          end
          2: begin
            lo = 64'd1 << $urandom_range(63);
            hi = $urandom_range(1) ? '0 : 64'd1 << $urandom_range(63);
          end
          3: begin
            lo = $urandom_range(1) ? '1 : '0;
            hi = $urandom_range(1) ? '1 : '0;
          end
          default: begin
            lo = lo & random_plane() & random_plane();
            hi = hi | random_plane();
          end
        endcase
      end
      maybe_idle();
      issue_tile(clr, lo, hi);
    end
  endtask

  initial begin
    #TIMEOUT_NS;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [PLANE_W-1:0] asym_lo;
    logic [PLANE_W-1:0] asym_hi;
    logic [PLANE_W-1:0] sym_lo;
    logic [PLANE_W-1:0] sym_hi;
    int                 phase;
    int                 directed_total;
    asym_lo = 64'h0123456789ABCDEF;
    asym_hi = 64'h00000000000000C1;
    sym_lo  = 64'h00244281FF7E3C18;
    sym_hi  = 64'h665AA5C3C3A55A66;
    rst <= 1'b1;
    start <= 1'b0;
    clear_table <= 1'b0;
    plane_low <= '0;
    plane_high <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Plane extremes, then a repeat of the blank tile.
    issue_tile(1'b0, '0, '0);
    issue_tile(1'b0, '1, '0);
    issue_tile(1'b0, '0, '1);
    issue_tile(1'b0, '1, '1);
    maybe_idle();
    issue_tile(1'b0, '0, '0);
    // An asymmetric tile and its three flipped versions.
    issue_tile(1'b0, asym_lo, asym_hi);
    issue_tile(1'b0, dedup_book::turn_plane(asym_lo, 1'b1, 1'b0),
               dedup_book::turn_plane(asym_hi, 1'b1, 1'b0));
    issue_tile(1'b0, dedup_book::turn_plane(asym_lo, 1'b0, 1'b1),
               dedup_book::turn_plane(asym_hi, 1'b0, 1'b1));
    issue_tile(1'b0, dedup_book::turn_plane(asym_lo, 1'b1, 1'b1),
               dedup_book::turn_plane(asym_hi, 1'b1, 1'b1));
    // Left-right symmetric tile: its vertical flip must report no horizontal flip.
    issue_tile(1'b0, sym_lo, sym_hi);
    issue_tile(1'b0, dedup_book::turn_plane(sym_lo, 1'b0, 1'b1),
               dedup_book::turn_plane(sym_hi, 1'b0, 1'b1));
    // Single pixel in each corner.
    issue_tile(1'b0, 64'h8000000000000000, '0);
    issue_tile(1'b0, 64'h0000000000000080, '0);
    issue_tile(1'b0, 64'h0100000000000000, '0);
    maybe_idle();
    issue_tile(1'b0, 64'h0000000000000001, '0);
    // Clears: old entries must never match again.
    issue_tile(1'b1, asym_lo, asym_hi);
    issue_tile(1'b0, '0, '0);
    issue_tile(1'b1, '1, '1);
    issue_tile(1'b0, '1, '1);
    directed_total = requests_sent;

    phase = 0;
    while (requests_sent - directed_total < RANDOM_TILES) begin
      allow_idle = !(phase >= 6 && phase < 10);
      if (phase == 3) begin
        // Send more fresh tiles than the table holds, then a run of hits and misses.
        run_episode(TABLE_DEPTH + 10, 100, 1'b1);
        run_episode(24, 25, 1'b0);
      end else begin
        run_episode($urandom_range(10, 40), 35, 1'b1);
      end
      if (phase % 4 == 1) begin
        wait_for_drain();
      end
      phase++;
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.expected_matches.size() != 0) begin
      $display("%0t: %0d results expected, 0 arrived", $time, book.expected_matches.size());
      book.failures++;
    end
    if (book.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/tdf_pkg.sv
src/tdf_ram.sv
src/tdf_match.sv
src/tile_dedup_with_flip_match.sv
verif/tb.sv
